FILE: rtl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared codes, defaults and types of the bit stack field store.
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int CAPACITY_BITS_DEF = 4096;
    localparam int VALUE_WIDTH_DEF   = 32;

    // Widest field offset and length for values of up to 64 bits.
    localparam int OFF_W = 6;
    localparam int LEN_W = 7;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_SET    = 2'd2;
    localparam logic [1:0] REQ_GET    = 2'd3;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             swap;
    } align_ctl_t;

endpackage

FILE: rtl/bsf_ram.sv
// ----------------------------------------------------------------------------
// bsf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bsf_align.sv
// ----------------------------------------------------------------------------
// bsf_align
// Extracts a field from two adjacent memory words and merges new bits into
// them for write-back.
// ----------------------------------------------------------------------------
module bsf_align #(
    parameter int WORD_W      = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  bsf_pkg::align_ctl_t    ctl,
    input  logic [WORD_W-1:0]      rd0,
    input  logic [WORD_W-1:0]      rd1,
    input  logic [VALUE_WIDTH-1:0] wdata,
    output logic [VALUE_WIDTH-1:0] field,
    output logic [WORD_W-1:0]      wr0,
    output logic [WORD_W-1:0]      wr1
);

    localparam int PAIR_W = 2 * WORD_W;

    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;
    logic [PAIR_W-1:0] pair;
    logic [PAIR_W-1:0] mask;
    logic [PAIR_W-1:0] shifted;
    logic [PAIR_W-1:0] merged;

    always_comb begin
        lo_word = ctl.swap ? rd1 : rd0;
        hi_word = ctl.swap ? rd0 : rd1;
        pair    = {hi_word, lo_word};
        mask    = ~({PAIR_W{1'b1}} << ctl.length);
        shifted = (pair >> ctl.offset) & mask;
        field   = shifted[VALUE_WIDTH-1:0];
        merged  = (pair & ~(mask << ctl.offset))
                | ((PAIR_W'(wdata) & mask) << ctl.offset);
        wr0     = ctl.swap ? merged[PAIR_W-1:WORD_W] : merged[WORD_W-1:0];
        wr1     = ctl.swap ? merged[WORD_W-1:0] : merged[PAIR_W-1:WORD_W];
    end

endmodule

FILE: rtl/bit_stack_field_store_unit.sv
// ----------------------------------------------------------------------------
// bit_stack_field_store_unit
// Bit store with a fill count: appends, field reads, single-bit set and get.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   request | in        | s_valid, s_ready, s_req_type .. s_bit_count
//   result  | out       | m_valid, m_ready, m_ok, m_read_data, m_used_bits
//
// Each request steps through accept, memory read, merge and write-back.
// The store is split over an even-word and an odd-word RAM, so a field that
// spans two words is read and written back in one pass.
// Requests are served one at a time; a result waiting in the output register
// does not block the next accept, only that request's merge cycle.
// Reset clears the fill count; the store needs no clearing pass.
module bit_stack_field_store_unit #(
    parameter int CAPACITY_BITS = bsf_pkg::CAPACITY_BITS_DEF,
    parameter int VALUE_WIDTH   = bsf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_req_type,
    input  logic [$clog2(CAPACITY_BITS)-1:0]       s_bit_index,
    input  logic                                   s_bit_value,
    input  logic [VALUE_WIDTH-1:0]                 s_write_data,
    input  logic [$clog2(VALUE_WIDTH+1)-1:0]       s_bit_count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_ok,
    output logic [VALUE_WIDTH-1:0]                 m_read_data,
    output logic [$clog2(CAPACITY_BITS+1)-1:0]     m_used_bits
);

    localparam int IDX_W      = $clog2(CAPACITY_BITS);
    localparam int USED_W     = $clog2(CAPACITY_BITS + 1);
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int LOG_W      = $clog2(VALUE_WIDTH);
    localparam int WORD_W     = 1 << LOG_W;
    localparam int POS_W      = (USED_W > LOG_W + 1) ? USED_W : LOG_W + 1;
    localparam int WA_W       = POS_W - LOG_W;
    localparam int CHK_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int WORDS      = (CAPACITY_BITS + WORD_W - 1) / WORD_W;
    localparam int BANK_DEPTH = (WORDS + 1) / 2 + 1;
    localparam int BA_W       = $clog2(BANK_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADDR  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [USED_W-1:0]      used_reg;

    logic [1:0]             req_type_reg;
    logic [IDX_W-1:0]       req_idx_reg;
    logic                   req_bval_reg;
    logic [VALUE_WIDTH-1:0] req_wdata_reg;
    logic [CNT_W-1:0]       req_cnt_reg;

    bsf_pkg::align_ctl_t    ctl_reg;
    logic                   ok_reg;
    logic                   wr_en_reg;
    logic [BA_W-1:0]        addr0_reg;
    logic [BA_W-1:0]        addr1_reg;
    logic [VALUE_WIDTH-1:0] wdata_reg;
    logic [USED_W-1:0]      used_new_reg;

    logic                   m_valid_reg;
    logic                   m_ok_reg;
    logic [VALUE_WIDTH-1:0] m_read_data_reg;
    logic [USED_W-1:0]      m_used_bits_reg;

    logic [CHK_W-1:0]       cnt_x;
    logic [CHK_W-1:0]       used_x;
    logic [CHK_W-1:0]       idx_x;
    logic [CHK_W-1:0]       sum_x;
    logic [CHK_W-1:0]       start_x;
    logic                   len_ok;
    logic                   in_range;
    logic                   ok_sel;
    logic                   wr_sel;
    logic [POS_W-1:0]       pos_sel;
    logic [bsf_pkg::LEN_W-1:0] len_sel;
    logic [VALUE_WIDTH-1:0] wdata_sel;
    logic [WA_W-1:0]        word_addr;
    logic [WA_W-1:0]        half_addr;
    logic [BA_W-1:0]        addr0;
    logic [BA_W-1:0]        addr1;
    logic [USED_W-1:0]      used_upd;
    bsf_pkg::align_ctl_t    ctl_sel;

    logic                   accept;
    logic                   out_free;
    logic                   commit;
    logic                   ram_we;
    logic [WORD_W-1:0]      rd0;
    logic [WORD_W-1:0]      rd1;
    logic [WORD_W-1:0]      wr0;
    logic [WORD_W-1:0]      wr1;
    logic [VALUE_WIDTH-1:0] field;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_MERGE) && out_free;
    assign ram_we   = commit && wr_en_reg;

    // Range checks and field placement for the captured request.
    always_comb begin
        cnt_x    = CHK_W'(req_cnt_reg);
        used_x   = CHK_W'(used_reg);
        idx_x    = CHK_W'(req_idx_reg);
        sum_x    = used_x + cnt_x;
        start_x  = idx_x + CHK_W'(1) - cnt_x;
        len_ok   = cnt_x <= CHK_W'(VALUE_WIDTH);
        in_range = idx_x < used_x;
        len_sel  = bsf_pkg::LEN_W'(req_cnt_reg);
        unique case (req_type_reg)
            bsf_pkg::REQ_APPEND: begin
                ok_sel    = len_ok && (sum_x <= CHK_W'(CAPACITY_BITS));
                wr_sel    = 1'b1;
                pos_sel   = POS_W'(used_x);
                wdata_sel = req_wdata_reg;
            end
            bsf_pkg::REQ_READ: begin
                ok_sel    = in_range && len_ok && (cnt_x <= idx_x + CHK_W'(1));
                wr_sel    = 1'b0;
                pos_sel   = POS_W'(start_x);
                wdata_sel = req_wdata_reg;
            end
            bsf_pkg::REQ_SET: begin
                ok_sel    = in_range;
                wr_sel    = 1'b1;
                pos_sel   = POS_W'(idx_x);
                len_sel   = bsf_pkg::LEN_W'(1);
                wdata_sel = {{(VALUE_WIDTH-1){1'b0}}, req_bval_reg};
            end
            default: begin
                ok_sel    = in_range;
                wr_sel    = 1'b0;
                pos_sel   = POS_W'(idx_x);
                len_sel   = bsf_pkg::LEN_W'(1);
                wdata_sel = req_wdata_reg;
            end
        endcase
        if (!ok_sel) begin
            len_sel = '0;
        end
        word_addr      = pos_sel[POS_W-1:LOG_W];
        half_addr      = word_addr >> 1;
        addr1          = BA_W'(half_addr);
        addr0          = BA_W'(half_addr + WA_W'(word_addr[0]));
        ctl_sel.offset = bsf_pkg::OFF_W'(pos_sel[LOG_W-1:0]);
        ctl_sel.length = len_sel;
        ctl_sel.swap   = word_addr[0];
        used_upd       = (ok_sel && (req_type_reg == bsf_pkg::REQ_APPEND))
                       ? USED_W'(sum_x) : used_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                used_reg    <= used_new_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg  <= s_req_type;
            req_idx_reg   <= s_bit_index;
            req_bval_reg  <= s_bit_value;
            req_wdata_reg <= s_write_data;
            req_cnt_reg   <= s_bit_count;
        end
        if (state_reg == ST_ADDR) begin
            ctl_reg      <= ctl_sel;
            ok_reg       <= ok_sel;
            wr_en_reg    <= ok_sel && wr_sel && (len_sel != '0);
            addr0_reg    <= addr0;
            addr1_reg    <= addr1;
            wdata_reg    <= wdata_sel;
            used_new_reg <= used_upd;
        end
        if (commit) begin
            m_ok_reg        <= ok_reg;
            m_read_data_reg <= wr_en_reg ? '0 : field;
            m_used_bits_reg <= used_new_reg;
        end
    end

    bsf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_ram_even (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr0_reg),
        .wdata (wr0),
        .re    (state_reg == ST_ADDR),
        .raddr (addr0),
        .rdata (rd0)
    );

    bsf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_ram_odd (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr1_reg),
        .wdata (wr1),
        .re    (state_reg == ST_ADDR),
        .raddr (addr1),
        .rdata (rd1)
    );

    bsf_align #(
        .WORD_W      (WORD_W),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_align (
        .ctl   (ctl_reg),
        .rd0   (rd0),
        .rd1   (rd1),
        .wdata (wdata_reg),
        .field (field),
        .wr0   (wr0),
        .wr1   (wr1)
    );

    assign m_valid     = m_valid_reg;
    assign m_ok        = m_ok_reg;
    assign m_read_data = m_read_data_reg;
    assign m_used_bits = m_used_bits_reg;

endmodule

FILE: rtl/bsf_checker.sv
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks of the bit stack field store, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker #(
    parameter int CAPACITY_BITS = bsf_pkg::CAPACITY_BITS_DEF,
    parameter int VALUE_WIDTH   = bsf_pkg::VALUE_WIDTH_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_ok,
    input logic [VALUE_WIDTH-1:0]             m_read_data,
    input logic [$clog2(CAPACITY_BITS+1)-1:0] m_used_bits
);

    // A stalled result transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_ok) && $stable(m_used_bits))
        else $error("result changed while stalled");

    // Requests are served one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    // A rejected request returns no data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_read_data == '0)
        else $error("rejected request returned data");

    // The fill count never exceeds the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_used_bits) <= CAPACITY_BITS)
        else $error("fill count beyond capacity");

endmodule

bind bit_stack_field_store_unit bsf_checker #(
    .CAPACITY_BITS (CAPACITY_BITS),
    .VALUE_WIDTH   (VALUE_WIDTH)
) u_bsf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_ok        (m_ok),
    .m_read_data (m_read_data),
    .m_used_bits (m_used_bits)
);

FILE: tb/sv/bit_stack_field_store_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_stack_field_store_unit_test
// Checks appends, field reads and single-bit set and get on the bit store.
// Requests go in through a directed list, then in three random phases:
// frequent receiver stalls, frequent sender stalls, then none. A scoreboard
// copies the store and fill count and compares every result transfer with it.
// ----------------------------------------------------------------------------

typedef struct {
    logic        ok;
    logic [31:0] read_data;
    logic [12:0] used_bits;
} store_result_t;

class field_store_scoreboard;
    logic          store_bits [4096];
    int            fill;
    store_result_t awaited [$];
    int            failures;

    function new();
        fill     = 0;
        failures = 0;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void note_request(logic [1:0] req, logic [11:0] index, logic value,
                               logic [31:0] wdata, logic [5:0] count);
        store_result_t res;
        int            cnt;
        int            idx;
        int            start;
        res.ok        = 1'b0;
        res.read_data = '0;
        cnt           = int'(count);
        idx           = int'(index);
        case (req)
            bsf_pkg::REQ_APPEND: begin
                if (cnt <= 32 && fill + cnt <= 4096) begin
                    for (int i = 0; i < cnt; i++) begin
                        store_bits[fill] = wdata[i];
                        fill++;
                    end
                    res.ok = 1'b1;
                end
            end
            bsf_pkg::REQ_READ: begin
                if (idx < fill && cnt <= 32 && cnt <= idx + 1) begin
                    start = idx + 1 - cnt;
                    for (int i = 0; i < cnt; i++)
                        res.read_data[i] = store_bits[start + i];
                    res.ok = 1'b1;
                end
            end
            bsf_pkg::REQ_SET: begin
                if (idx < fill) begin
                    store_bits[idx] = value;
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (idx < fill) begin
                    res.read_data[0] = store_bits[idx];
                    res.ok = 1'b1;
                end
            end
        endcase
        res.used_bits = 13'(fill);
        awaited.push_back(res);
    endfunction

    function void check_result(logic ok, logic [31:0] read_data, logic [12:0] used_bits);
        store_result_t res;
        if (awaited.size() == 0) begin
            $error("result transfer with no request outstanding");
            failures++;
            return;
        end
        res = awaited.pop_front();
        if (ok !== res.ok) begin
            $error("ok: expected %0d, actual %0d", res.ok, ok);
            failures++;
        end
        if (read_data !== res.read_data) begin
            $error("read_data: expected 0x%08h, actual 0x%08h", res.read_data, read_data);
            failures++;
        end
        if (used_bits !== res.used_bits) begin
            $error("used_bits: expected %0d, actual %0d", res.used_bits, used_bits);
            failures++;
        end
    endfunction
endclass

module bit_stack_field_store_unit_test;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type   = bsf_pkg::REQ_GET;
    logic [11:0] s_bit_index  = '0;
    logic        s_bit_value  = 1'b0;
    logic [31:0] s_write_data = '0;
    logic [5:0]  s_bit_count  = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_ok;
    logic [31:0] m_read_data;
    logic [12:0] m_used_bits;

    int tx_idle_pct = 8;
    int rx_idle_pct = 74;

    field_store_scoreboard sb = new();

    bit_stack_field_store_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_bit_index  (s_bit_index),
        .s_bit_value  (s_bit_value),
        .s_write_data (s_write_data),
        .s_bit_count  (s_bit_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_read_data  (m_read_data),
        .m_used_bits  (m_used_bits)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid === 1'b1 && s_ready === 1'b1)
                sb.note_request(s_req_type, s_bit_index, s_bit_value, s_write_data,
                                s_bit_count);
            if (m_valid === 1'b1 && m_ready === 1'b1)
                sb.check_result(m_ok, m_read_data, m_used_bits);
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [11:0] index,
                                input logic value, input logic [31:0] wdata,
                                input logic [5:0] count);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_bit_index  <= index;
        s_bit_value  <= value;
        s_write_data <= wdata;
        s_bit_count  <= count;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
    endtask

    // Mostly positions inside the filled region, with a bias toward its end.
    function automatic logic [11:0] pick_index(int fill);
        int pick;
        pick = $urandom_range(99);
        if (fill == 0 || pick < 20)
            return 12'($urandom_range(4095));
        if (pick < 55)
            return 12'(fill - 1 - $urandom_range((fill - 1 < 40) ? fill - 1 : 40));
        return 12'($urandom_range(fill - 1));
    endfunction

    task automatic run_random_phase(input int items);
        logic [1:0]  req;
        logic [11:0] index;
        logic [5:0]  count;
        int          pick;
        int          limit;
        for (int n = 0; n < items; n++) begin
            pick  = $urandom_range(99);
            index = pick_index(sb.fill);
            if (pick < 30) begin
                req   = bsf_pkg::REQ_APPEND;
                count = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                                 : 6'($urandom_range(32));
            end else if (pick < 60) begin
                req   = bsf_pkg::REQ_READ;
                limit = (int'(index) + 1 < 32) ? int'(index) + 1 : 32;
                count = ($urandom_range(99) < 85) ? 6'($urandom_range(limit))
                                                  : 6'($urandom_range(63));
            end else begin
                req   = (pick < 80) ? bsf_pkg::REQ_SET : bsf_pkg::REQ_GET;
                count = 6'($urandom_range(63));
            end
            send_request(req, index, 1'($urandom_range(1)), $urandom, count);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(bsf_pkg::REQ_READ,   12'd0,    1'b0, 32'h0,        6'd1);
        send_request(bsf_pkg::REQ_GET,    12'd0,    1'b0, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_SET,    12'd0,    1'b1, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_APPEND, 12'd0,    1'b0, 32'hFFFFFFFF, 6'd0);
        send_request(bsf_pkg::REQ_APPEND, 12'd0,    1'b0, 32'hFFFFFFFF, 6'd33);
        send_request(bsf_pkg::REQ_APPEND, 12'hFFF,  1'b1, 32'hFFFFFFFF, 6'd63);
        send_request(bsf_pkg::REQ_APPEND, 12'd0,    1'b0, 32'hFFFFFFFF, 6'd32);
        send_request(bsf_pkg::REQ_APPEND, 12'd0,    1'b0, 32'h00000000, 6'd32);
        send_request(bsf_pkg::REQ_APPEND, 12'd0,    1'b0, 32'h00000001, 6'd1);
        send_request(bsf_pkg::REQ_APPEND, 12'd0,    1'b0, 32'hA5A5A5A5, 6'd31);
        send_request(bsf_pkg::REQ_READ,   12'd31,   1'b0, 32'h0,        6'd32);
        send_request(bsf_pkg::REQ_READ,   12'd40,   1'b0, 32'h0,        6'd16);
        send_request(bsf_pkg::REQ_READ,   12'd5,    1'b0, 32'h0,        6'd7);
        send_request(bsf_pkg::REQ_READ,   12'd63,   1'b0, 32'h0,        6'd33);
        send_request(bsf_pkg::REQ_READ,   12'd0,    1'b0, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_READ,   12'd95,   1'b0, 32'h0,        6'd32);
        send_request(bsf_pkg::REQ_READ,   12'd96,   1'b0, 32'h0,        6'd1);
        send_request(bsf_pkg::REQ_SET,    12'd10,   1'b0, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_GET,    12'd10,   1'b0, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_SET,    12'd40,   1'b1, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_GET,    12'd40,   1'b0, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_GET,    12'd96,   1'b0, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_SET,    12'hFFF,  1'b1, 32'h0,        6'd0);
        send_request(bsf_pkg::REQ_READ,   12'hFFF,  1'b0, 32'h0,        6'd63);
        send_request(bsf_pkg::REQ_READ,   12'd70,   1'b0, 32'h0,        6'd32);

        run_random_phase(460);
        tx_idle_pct = 74;
        rx_idle_pct = 8;
        run_random_phase(460);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(460);
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("bit_stack_field_store_unit test passed");
        else
            $display("bit_stack_field_store_unit test failed");
        $finish;
    end

    initial begin
        #1000000;
        $display("bit_stack_field_store_unit test failed");
        $finish;
    end

endmodule
